// File: design/aabb_collision_resolve_core_macros.svh
// Assertion macros used by the checker file of the box collision core.
`ifndef AABB_COLLISION_RESOLVE_CORE_MACROS_SVH
`define AABB_COLLISION_RESOLVE_CORE_MACROS_SVH

// check on every clock edge outside reset
`define AABB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("aabb core check failed");

// check on every clock edge, reset included
`define AABB_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("aabb core reset check failed");

`endif

// File: design/aabb_cr_pkg.sv
// Shared constants, types and helper functions of the box collision core.
package aabb_cr_pkg;

  localparam int unsigned CF_W       = 9;
  localparam logic [8:0]  CF_RESET   = 9'd205;
  localparam int unsigned IN_DATA_W  = 216;
  localparam int unsigned OUT_DATA_W = 120;
  localparam int unsigned NUM_W      = 33;
  localparam int unsigned DEN_W      = 17;
  localparam int unsigned Q_W        = 18;
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = Q_W / DIV_STEPS;

  localparam logic [1:0] NORM_POS_X = 2'd0;
  localparam logic [1:0] NORM_NEG_X = 2'd1;
  localparam logic [1:0] NORM_POS_Y = 2'd2;
  localparam logic [1:0] NORM_NEG_Y = 2'd3;

  typedef struct packed {
    logic        hit;
    logic [1:0]  code;
    logic [15:0] depth;
    logic        neg;
    logic        sta;
    logic        stb;
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic        inv_zero;
    logic [31:0] va;
    logic [31:0] vb;
  } meta_t;

  // drop the 8 fraction bits of the Q1.8 factor truncating toward zero, negate and saturate
  function automatic logic [15:0] reflect_sat(input logic signed [25:0] p);
    logic signed [25:0] bias;
    logic signed [25:0] t;
    logic signed [25:0] n;
    bias = p[25] ? 26'sd255 : 26'sd0;
    t = (p + bias) >>> 8;
    n = -t;
    if (n > 26'sd32767) begin
      return 16'h7fff;
    end else if (n < -26'sd32768) begin
      return 16'h8000;
    end
    return n[15:0];
  endfunction

  function automatic logic [15:0] shift_sat(input logic [Q_W-1:0] q, input logic neg);
    logic big;
    big = (q[Q_W-1:15] != '0);
    if (neg) begin
      return big ? 16'h8000 : 16'(16'd0 - q[15:0]);
    end
    return big ? 16'h7fff : q[15:0];
  endfunction

endpackage

// File: design/aabb_cr_front.sv
// Front stages: overlap test, axis pick, velocity reflection, depth times factor.
module aabb_cr_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [15:0]            offset_x_i,
  input  logic [15:0]            offset_y_i,
  input  logic [31:0]            size_a_i,
  input  logic [31:0]            size_b_i,
  input  logic [15:0]            inv_mass_a_i,
  input  logic [15:0]            inv_mass_b_i,
  input  logic [8:0]             bounce_a_i,
  input  logic [8:0]             bounce_b_i,
  input  logic [1:0]             static_flags_i,
  input  logic [31:0]            velocity_a_i,
  input  logic [31:0]            velocity_b_i,
  input  logic [8:0]             cf_i,
  output logic                   valid_o,
  output aabb_cr_pkg::ctl_t      ctl_o,
  output logic [24:0]            prod_o,
  output logic [15:0]            inv_mass_a_o,
  output logic [15:0]            inv_mass_b_o,
  output logic [31:0]            new_velocity_a_o,
  output logic [31:0]            new_velocity_b_o
);

  // stage A
  logic [16:0]        ax, ay;
  logic signed [18:0] ox2_d, oy2_d;
  logic [8:0]         r_d;
  logic               a_valid_q;
  logic signed [18:0] a_ox2_q, a_oy2_q;
  logic               a_negx_q, a_negy_q, a_sta_q, a_stb_q;
  logic [15:0]        a_ima_q, a_imb_q;
  logic [8:0]         a_r_q;
  logic [31:0]        a_va_q, a_vb_q;

  assign ax = offset_x_i[15] ? 17'(17'd0 - {offset_x_i[15], offset_x_i})
                             : {1'b0, offset_x_i};
  assign ay = offset_y_i[15] ? 17'(17'd0 - {offset_y_i[15], offset_y_i})
                             : {1'b0, offset_y_i};
  assign ox2_d = $signed({3'b0, size_a_i[15:0]} + {3'b0, size_b_i[15:0]} - {1'b0, ax, 1'b0});
  assign oy2_d = $signed({3'b0, size_a_i[31:16]} + {3'b0, size_b_i[31:16]} - {1'b0, ay, 1'b0});
  assign r_d   = (bounce_a_i < bounce_b_i) ? bounce_a_i : bounce_b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_ox2_q  <= ox2_d;
      a_oy2_q  <= oy2_d;
      a_negx_q <= offset_x_i[15];
      a_negy_q <= offset_y_i[15];
      a_sta_q  <= static_flags_i[0];
      a_stb_q  <= static_flags_i[1];
      a_ima_q  <= inv_mass_a_i;
      a_imb_q  <= inv_mass_b_i;
      a_r_q    <= r_d;
      a_va_q   <= velocity_a_i;
      a_vb_q   <= velocity_b_i;
    end
  end

  // stage B
  logic               yaxis, hit, neg;
  logic [15:0]        depth;
  logic [1:0]         code;
  logic [15:0]        comp_a, comp_b;
  logic signed [25:0] pa_d, pb_d;
  aabb_cr_pkg::ctl_t  ctl_d;
  logic               b_valid_q, b_yaxis_q;
  aabb_cr_pkg::ctl_t  b_ctl_q;
  logic signed [25:0] b_pa_q, b_pb_q;
  logic [15:0]        b_ima_q, b_imb_q;
  logic [31:0]        b_va_q, b_vb_q;

  always_comb begin
    yaxis  = !(a_ox2_q < a_oy2_q);
    hit    = !(a_sta_q && a_stb_q) && (a_ox2_q > 19'sd0) && (a_oy2_q > 19'sd0);
    neg    = yaxis ? a_negy_q : a_negx_q;
    depth  = yaxis ? a_oy2_q[16:1] : a_ox2_q[16:1];
    if (yaxis) begin
      code = neg ? aabb_cr_pkg::NORM_NEG_Y : aabb_cr_pkg::NORM_POS_Y;
    end else begin
      code = neg ? aabb_cr_pkg::NORM_NEG_X : aabb_cr_pkg::NORM_POS_X;
    end
    comp_a = yaxis ? a_va_q[31:16] : a_va_q[15:0];
    comp_b = yaxis ? a_vb_q[31:16] : a_vb_q[15:0];
    pa_d   = $signed(comp_a) * $signed({1'b0, a_r_q});
    pb_d   = $signed(comp_b) * $signed({1'b0, a_r_q});
    ctl_d.hit   = hit;
    ctl_d.code  = hit ? code : aabb_cr_pkg::NORM_POS_X;
    ctl_d.depth = hit ? depth : 16'd0;
    ctl_d.neg   = neg;
    ctl_d.sta   = a_sta_q;
    ctl_d.stb   = a_stb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_yaxis_q <= yaxis;
      b_ctl_q   <= ctl_d;
      b_pa_q    <= pa_d;
      b_pb_q    <= pb_d;
      b_ima_q   <= a_ima_q;
      b_imb_q   <= a_imb_q;
      b_va_q    <= a_va_q;
      b_vb_q    <= a_vb_q;
    end
  end

  // stage C
  logic [15:0] refl_a, refl_b;
  logic [31:0] nva_d, nvb_d;
  logic [24:0] prod_d;
  logic        c_valid_q;

  always_comb begin
    refl_a = aabb_cr_pkg::reflect_sat(b_pa_q);
    refl_b = aabb_cr_pkg::reflect_sat(b_pb_q);
    nva_d  = b_va_q;
    nvb_d  = b_vb_q;
    if (b_ctl_q.hit && !b_ctl_q.sta) begin
      nva_d = b_yaxis_q ? {refl_a, b_va_q[15:0]} : {b_va_q[31:16], refl_a};
    end
    if (b_ctl_q.hit && !b_ctl_q.stb) begin
      nvb_d = b_yaxis_q ? {refl_b, b_vb_q[15:0]} : {b_vb_q[31:16], refl_b};
    end
    prod_d = b_ctl_q.depth * cf_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en_i) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o            <= b_ctl_q;
      prod_o           <= prod_d;
      inv_mass_a_o     <= b_ima_q;
      inv_mass_b_o     <= b_imb_q;
      new_velocity_a_o <= nva_d;
      new_velocity_b_o <= nvb_d;
    end
  end

  assign valid_o = c_valid_q;

endmodule

// File: design/aabb_cr_div.sv
// Pipelined restoring divider, three quotient bits per stage.
module aabb_cr_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [aabb_cr_pkg::NUM_W-1:0]   num_i,
  input  logic [aabb_cr_pkg::DEN_W-1:0]   den_i,
  output logic [aabb_cr_pkg::Q_W-1:0]     quo_o
);

  localparam int unsigned QW = aabb_cr_pkg::Q_W;
  localparam int unsigned DW = aabb_cr_pkg::DEN_W;
  localparam int unsigned NS = aabb_cr_pkg::DIV_STAGES;
  localparam int unsigned NH = aabb_cr_pkg::NUM_W - QW;

  logic [QW-1:0] rem_in [NS];
  logic [QW-1:0] low_in [NS];
  logic [QW-1:0] quo_in [NS];
  logic [DW-1:0] den_in [NS];
  logic [QW-1:0] rem_q  [NS];
  logic [QW-1:0] low_q  [NS];
  logic [QW-1:0] quo_q  [NS];
  logic [DW-1:0] den_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [QW-1:0] rem_d, low_d, quo_d;
    logic [QW-1:0] t;

    if (s == 0) begin : g_first
      assign rem_in[s] = {{(QW - NH){1'b0}}, num_i[aabb_cr_pkg::NUM_W-1:QW]};
      assign low_in[s] = num_i[QW-1:0];
      assign quo_in[s] = '0;
      assign den_in[s] = den_i;
    end else begin : g_next
      assign rem_in[s] = rem_q[s-1];
      assign low_in[s] = low_q[s-1];
      assign quo_in[s] = quo_q[s-1];
      assign den_in[s] = den_q[s-1];
    end

    always_comb begin
      rem_d = rem_in[s];
      low_d = low_in[s];
      quo_d = quo_in[s];
      t     = '0;
      for (int k = 0; k < aabb_cr_pkg::DIV_STEPS; k++) begin
        t     = {rem_d[QW-2:0], low_d[QW-1]};
        low_d = {low_d[QW-2:0], 1'b0};
        if (t >= {1'b0, den_in[s]}) begin
          rem_d = t - {1'b0, den_in[s]};
          quo_d = {quo_d[QW-2:0], 1'b1};
        end else begin
          rem_d = t;
          quo_d = {quo_d[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        low_q[s] <= low_d;
        quo_q[s] <= quo_d;
        den_q[s] <= den_in[s];
      end
    end
  end

  assign quo_o = quo_q[NS-1];

endmodule

// File: design/aabb_collision_resolve_core.sv
// Top level of the box pair collision test and response pipeline.
//
//  channel   | dir | handshake                     | beat contents
//  ----------+-----+-------------------------------+--------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | box pair, static flags in tuser
//  m_axis    | out | m_axis_tvalid / m_axis_tready | contact result, hit in tuser
//  cfg       | in  | cfg_we_i                      | correction factor, Q1.8
//
//  One beat per cycle sustained while the output is not stalled; the stages are three
//  front stages, one mass product stage, six divider stages of three quotient bits, output.
//  The whole pipeline holds while the output beat is stalled.
//  Reset clears valid bits and loads the correction factor with 205.
module aabb_collision_resolve_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // offset_x, offset_y, size_a, size_b, inv_mass_a, inv_mass_b,
  // bounce_a, bounce_b, velocity_a, velocity_b
  input  logic [aabb_cr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // static_flags
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // normal_code, depth, shift_a, shift_b, new_velocity_a, new_velocity_b
  output logic [aabb_cr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // hit
  output logic                                m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [aabb_cr_pkg::CF_W-1:0]        cfg_wdata_i
);

  localparam int unsigned NS = aabb_cr_pkg::DIV_STAGES;

  logic                          en;
  logic [aabb_cr_pkg::CF_W-1:0]  cf_q;
  logic                          out_valid_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cf_q <= aabb_cr_pkg::CF_RESET;
    end else if (cfg_we_i) begin
      cf_q <= cfg_wdata_i;
    end
  end

  logic              c_valid;
  aabb_cr_pkg::ctl_t c_ctl;
  logic [24:0]       c_prod;
  logic [15:0]       c_ima, c_imb;
  logic [31:0]       c_nva, c_nvb;

  aabb_cr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (en),
    .valid_i          (s_axis_tvalid),
    .offset_x_i       (s_axis_tdata[15:0]),
    .offset_y_i       (s_axis_tdata[31:16]),
    .size_a_i         (s_axis_tdata[63:32]),
    .size_b_i         (s_axis_tdata[95:64]),
    .inv_mass_a_i     (s_axis_tdata[111:96]),
    .inv_mass_b_i     (s_axis_tdata[127:112]),
    .bounce_a_i       (s_axis_tdata[136:128]),
    .bounce_b_i       (s_axis_tdata[145:137]),
    .static_flags_i   (s_axis_tuser),
    .velocity_a_i     (s_axis_tdata[177:146]),
    .velocity_b_i     (s_axis_tdata[209:178]),
    .cf_i             (cf_q),
    .valid_o          (c_valid),
    .ctl_o            (c_ctl),
    .prod_o           (c_prod),
    .inv_mass_a_o     (c_ima),
    .inv_mass_b_o     (c_imb),
    .new_velocity_a_o (c_nva),
    .new_velocity_b_o (c_nvb)
  );

  // mass product stage
  logic [40:0]                        full_a, full_b;
  logic [aabb_cr_pkg::DEN_W-1:0]      invsum;
  logic                               d_valid_q;
  logic [aabb_cr_pkg::NUM_W-1:0]      d_num_a_q, d_num_b_q;
  logic [aabb_cr_pkg::DEN_W-1:0]      d_den_q;
  aabb_cr_pkg::meta_t                 d_meta_q;

  assign full_a = c_prod * c_ima;
  assign full_b = c_prod * c_imb;
  assign invsum = {1'b0, c_ima} + {1'b0, c_imb};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_num_a_q         <= full_a[40:8];
      d_num_b_q         <= full_b[40:8];
      d_den_q           <= invsum;
      d_meta_q.ctl      <= c_ctl;
      d_meta_q.inv_zero <= (invsum == '0);
      d_meta_q.va       <= c_nva;
      d_meta_q.vb       <= c_nvb;
    end
  end

  logic [aabb_cr_pkg::Q_W-1:0] quo_a, quo_b;

  aabb_cr_div u_div_a (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (d_num_a_q),
    .den_i (d_den_q),
    .quo_o (quo_a)
  );

  aabb_cr_div u_div_b (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (d_num_b_q),
    .den_i (d_den_q),
    .quo_o (quo_b)
  );

  // carry side data alongside the divider stages
  logic               dv_valid_q [NS];
  aabb_cr_pkg::meta_t dv_meta_q  [NS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) begin
        dv_valid_q[i] <= 1'b0;
      end
    end else if (en) begin
      dv_valid_q[0] <= d_valid_q;
      for (int i = 1; i < NS; i++) begin
        dv_valid_q[i] <= dv_valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_meta_q[0] <= d_meta_q;
      for (int i = 1; i < NS; i++) begin
        dv_meta_q[i] <= dv_meta_q[i-1];
      end
    end
  end

  // output stage
  aabb_cr_pkg::meta_t m;
  logic [15:0]        shift_a_d, shift_b_d;
  logic [aabb_cr_pkg::OUT_DATA_W-1:0] data_d;
  logic [aabb_cr_pkg::OUT_DATA_W-1:0] data_q;
  logic               hit_q;

  always_comb begin
    m         = dv_meta_q[NS-1];
    shift_a_d = 16'd0;
    shift_b_d = 16'd0;
    if (m.ctl.hit && !m.inv_zero && !m.ctl.sta) begin
      shift_a_d = aabb_cr_pkg::shift_sat(quo_a, !m.ctl.neg);
    end
    if (m.ctl.hit && !m.inv_zero && !m.ctl.stb) begin
      shift_b_d = aabb_cr_pkg::shift_sat(quo_b, m.ctl.neg);
    end
    data_d = {6'd0, m.vb, m.va, shift_b_d, shift_a_d, m.ctl.depth, m.ctl.code};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q <= data_d;
      hit_q  <= m.ctl.hit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = hit_q;

endmodule

// File: design/aabb_cr_checker.sv
// Port-level checker of the box collision core and its bind.
`include "aabb_collision_resolve_core_macros.svh"

module aabb_cr_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [aabb_cr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input logic [1:0]                          s_axis_tuser,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [aabb_cr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                                m_axis_tuser,
  input logic                                cfg_we_i,
  input logic [aabb_cr_pkg::CF_W-1:0]        cfg_wdata_i
);

  `AABB_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `AABB_ASSERT(a_nohit_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[49:0] == 50'd0)
  `AABB_ASSERT(a_ready_stall, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
  `AABB_ASSERT_RST(a_rst_idle, !rst_ni |=> !m_axis_tvalid)

endmodule

bind aabb_collision_resolve_core aabb_cr_checker u_aabb_cr_checker (.*);

// File: tb/aabb_collision_resolve_core_tb.sv
// Self-checking testbench of the box pair collision test and response core.
`timescale 1ns / 1ps

module aabb_collision_resolve_core_tb;

  typedef struct {
    logic [15:0] offset_x;
    logic [15:0] offset_y;
    logic [31:0] size_a;
    logic [31:0] size_b;
    logic [15:0] inv_mass_a;
    logic [15:0] inv_mass_b;
    logic [8:0]  bounce_a;
    logic [8:0]  bounce_b;
    logic [1:0]  static_flags;
    logic [31:0] velocity_a;
    logic [31:0] velocity_b;
  } pair_t;

  typedef struct {
    logic        hit;
    logic [1:0]  code;
    logic [15:0] depth;
    logic [15:0] shift_a;
    logic [15:0] shift_b;
    logic [31:0] vel_a;
    logic [31:0] vel_b;
  } contact_t;

  localparam longint unsigned CYCLE_LIMIT = 3000000;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [aabb_cr_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]                         s_axis_tuser = '0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [aabb_cr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                               m_axis_tuser;
  logic                               cfg_we_i = 1'b0;
  logic [aabb_cr_pkg::CF_W-1:0]       cfg_wdata_i = '0;

  contact_t        contact_q[$];
  logic [8:0]      corr_factor = aabb_cr_pkg::CF_RESET;
  int unsigned     err_cnt = 0;
  longint unsigned cycle_cnt = 0;
  bit              stall_en = 1'b1;

  aabb_collision_resolve_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("aabb_collision_resolve_core_tb: errors");
      $finish;
    end
  end

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [15:0] bounce_back(logic [15:0] v, logic [8:0] r);
    longint prod;
    prod = longint'($signed(v)) * longint'(r);
    return 16'(sat16(-(prod / 256)));
  endfunction

  function automatic logic [15:0] push_out(longint depth, longint inv, longint inv_sum,
                                           bit neg);
    longint mag;
    if (inv_sum == 0) return 16'd0;
    mag = (depth * longint'(corr_factor) * inv) / (inv_sum * 256);
    if (mag > 65536) mag = 65536;
    return 16'(sat16(neg ? -mag : mag));
  endfunction

  function automatic contact_t resolve_pair(pair_t p);
    contact_t c;
    longint nx, ny, ox2, oy2, depth, inv_sum;
    bit yaxis, neg;
    logic [8:0] r;
    c = '{1'b0, 2'd0, 16'd0, 16'd0, 16'd0, p.velocity_a, p.velocity_b};
    if (p.static_flags == 2'b11) return c;
    nx = longint'($signed(p.offset_x));
    ny = longint'($signed(p.offset_y));
    ox2 = longint'(p.size_a[15:0]) + longint'(p.size_b[15:0]) - 2 * (nx < 0 ? -nx : nx);
    oy2 = longint'(p.size_a[31:16]) + longint'(p.size_b[31:16]) - 2 * (ny < 0 ? -ny : ny);
    if (ox2 <= 0 || oy2 <= 0) return c;
    yaxis = !(ox2 < oy2);
    if (yaxis) begin
      neg = ny < 0;
      depth = oy2 >> 1;
      c.code = neg ? aabb_cr_pkg::NORM_NEG_Y : aabb_cr_pkg::NORM_POS_Y;
    end else begin
      neg = nx < 0;
      depth = ox2 >> 1;
      c.code = neg ? aabb_cr_pkg::NORM_NEG_X : aabb_cr_pkg::NORM_POS_X;
    end
    depth = depth & 64'hffff;
    inv_sum = longint'(p.inv_mass_a) + longint'(p.inv_mass_b);
    r = p.bounce_a < p.bounce_b ? p.bounce_a : p.bounce_b;
    c.hit = 1'b1;
    c.depth = 16'(depth);
    if (!p.static_flags[0]) begin
      c.shift_a = push_out(depth, longint'(p.inv_mass_a), inv_sum, !neg);
      if (yaxis) c.vel_a[31:16] = bounce_back(p.velocity_a[31:16], r);
      else c.vel_a[15:0] = bounce_back(p.velocity_a[15:0], r);
    end
    if (!p.static_flags[1]) begin
      c.shift_b = push_out(depth, longint'(p.inv_mass_b), inv_sum, neg);
      if (yaxis) c.vel_b[31:16] = bounce_back(p.velocity_b[31:16], r);
      else c.vel_b[15:0] = bounce_back(p.velocity_b[15:0], r);
    end
    return c;
  endfunction

  task automatic send_pair(pair_t p, int unsigned gap);
    bit rdy;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= p.static_flags;
    s_axis_tdata  <= {6'd0, p.velocity_b, p.velocity_a, p.bounce_b, p.bounce_a,
                      p.inv_mass_b, p.inv_mass_a, p.size_b, p.size_a,
                      p.offset_y, p.offset_x};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    contact_q.push_back(resolve_pair(p));
  endtask

  task automatic send_gapped(pair_t p);
    send_pair(p, stall_en ? $urandom_range(0, 16) : 0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (contact_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_correction(logic [8:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    corr_factor = v;
  endtask

  // drive the result side: random stalls per beat while stall_en is set
  initial begin
    bit acc;
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      n = stall_en ? $urandom_range(0, 16) : 0;
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        acc = m_axis_tvalid;
        @(posedge clk_i);
      end while (!acc);
    end
  end

  always @(negedge clk_i) begin
    contact_t exp_c;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (contact_q.size() == 0) begin
        $display("%0t: unexpected beat tuser=%h tdata=%h", $time, m_axis_tuser, m_axis_tdata);
        err_cnt++;
      end else begin
        exp_c = contact_q.pop_front();
        if ({exp_c.vel_b, exp_c.vel_a, exp_c.shift_b, exp_c.shift_a, exp_c.depth, exp_c.code}
            !== m_axis_tdata[113:0] || exp_c.hit !== m_axis_tuser ||
            m_axis_tdata[119:114] !== 6'd0) begin
          $display("%0t: mismatch exp hit=%b code=%0d depth=%h sa=%h sb=%h va=%h vb=%h",
                   $time, exp_c.hit, exp_c.code, exp_c.depth, exp_c.shift_a, exp_c.shift_b,
                   exp_c.vel_a, exp_c.vel_b);
          $display("%0t:          act hit=%b code=%0d depth=%h sa=%h sb=%h va=%h vb=%h",
                   $time, m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[17:2],
                   m_axis_tdata[33:18], m_axis_tdata[49:34], m_axis_tdata[81:50],
                   m_axis_tdata[113:82]);
          err_cnt++;
        end
      end
    end
  end

  function automatic pair_t noise_pair();
    pair_t p;
    p.offset_x = $urandom; p.offset_y = $urandom;
    p.size_a = $urandom; p.size_b = $urandom;
    p.inv_mass_a = $urandom; p.inv_mass_b = $urandom;
    p.bounce_a = $urandom; p.bounce_b = $urandom;
    p.static_flags = $urandom;
    p.velocity_a = $urandom; p.velocity_b = $urandom;
    return p;
  endfunction

  function automatic logic [15:0] near_offset(int unsigned sum);
    int lim, o;
    lim = sum / 2 + 2;
    o = int'($urandom_range(0, lim)) * ($urandom_range(0, 1) ? -1 : 1);
    if (o > 32767) o = 32767;
    if (o < -32768) o = -32768;
    return 16'(o);
  endfunction

  function automatic pair_t touching_pair();
    pair_t p;
    int unsigned hi;
    p = noise_pair();
    hi = ($urandom_range(0, 9) == 0) ? 65535 : 4000;
    p.size_a = {16'($urandom_range(0, hi)), 16'($urandom_range(0, hi))};
    p.size_b = {16'($urandom_range(0, hi)), 16'($urandom_range(0, hi))};
    p.offset_x = near_offset(p.size_a[15:0] + p.size_b[15:0]);
    p.offset_y = near_offset(p.size_a[31:16] + p.size_b[31:16]);
    case ($urandom_range(0, 5))
      0: p.inv_mass_a = 0;
      1: p.inv_mass_b = 0;
      2: begin p.inv_mass_a = $urandom_range(0, 1024); p.inv_mass_b = $urandom_range(0, 1024); end
      default: ;
    endcase
    if ($urandom_range(0, 4) != 0) begin
      p.bounce_a = $urandom_range(0, 256);
      p.bounce_b = $urandom_range(0, 256);
    end
    if ($urandom_range(0, 3) != 0) p.static_flags = $urandom_range(0, 2);
    return p;
  endfunction

  task automatic test_directed();
    pair_t b, p;
    b = '{16'd0, 16'd0, 32'h0100_0100, 32'h0100_0100, 16'h0100, 16'h0100,
          9'd128, 9'd200, 2'b00, 32'hff00_0180, 32'h0040_ffc0};
    p = b; send_pair(p, 0);
    p = b; p.offset_x = 16'h0040; send_pair(p, 0);
    p = b; p.offset_x = 16'hffc0; send_pair(p, 1);
    p = b; p.offset_y = 16'h0040; p.offset_x = 16'h0010; send_pair(p, 0);
    p = b; p.offset_y = 16'hffc0; p.offset_x = 16'h0010; send_pair(p, 0);
    p = b; p.static_flags = 2'b11; send_pair(p, 0);
    p = b; p.static_flags = 2'b01; p.offset_x = 16'h0020; send_pair(p, 0);
    p = b; p.static_flags = 2'b10; p.offset_x = 16'hffe0; send_pair(p, 0);
    p = b; p.offset_x = 16'h0100; send_pair(p, 0);
    p = b; p.size_a = 32'h0100_0101; p.offset_x = 16'h0100; send_pair(p, 0);
    p = b; p.inv_mass_a = 0; p.inv_mass_b = 0; send_pair(p, 0);
    p = b; p.inv_mass_a = 16'hffff; p.inv_mass_b = 0; send_pair(p, 2);
    p = b; p.size_a = 32'hffff_ffff; p.size_b = 32'hffff_ffff; p.offset_x = 16'h8000;
    p.offset_y = 16'h7fff; p.inv_mass_a = 16'hffff; p.inv_mass_b = 16'hffff; send_pair(p, 0);
    p = b; p.size_a = 32'hffff_ffff; p.size_b = 32'hffff_ffff; p.inv_mass_b = 16'd1;
    p.bounce_a = 9'h1ff; p.bounce_b = 9'h1ff; p.velocity_a = 32'h8000_8000;
    p.velocity_b = 32'h7fff_7fff; send_pair(p, 0);
    p = b; p.bounce_a = 9'd0; p.velocity_a = 32'hffff_ffff; send_pair(p, 0);
    p = b; p.bounce_a = 9'd256; p.bounce_b = 9'd256; p.velocity_a = 32'h8000_8000;
    send_pair(p, 0);
    p = b; p.velocity_a = 32'hffff_ff01; p.bounce_a = 9'd3; p.bounce_b = 9'd3; send_pair(p, 0);
    p = b; p.size_a = 32'h0; p.size_b = 32'h0; send_pair(p, 0);
    p = b; p.offset_x = 16'h7fff; p.offset_y = 16'h8000; send_pair(p, 0);
    drain();
  endtask

  task automatic test_correction_range();
    logic [8:0] cfs[5] = '{9'd0, 9'd256, 9'd511, 9'd1, aabb_cr_pkg::CF_RESET};
    foreach (cfs[i]) begin
      set_correction(cfs[i]);
      repeat (40) send_gapped(touching_pair());
    end
  endtask

  task automatic test_random();
    for (int k = 0; k < 1500; k++) begin
      if (k % 250 == 0) begin
        stall_en = (k % 500 != 250);
        set_correction(9'($urandom_range(0, 300)));
      end
      send_gapped($urandom_range(0, 4) == 0 ? noise_pair() : touching_pair());
    end
    stall_en = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_correction_range();
    test_random();
    drain();
    if (err_cnt == 0) begin
      $display("aabb_collision_resolve_core_tb: clean");
    end else begin
      $display("aabb_collision_resolve_core_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/aabb_cr_pkg.sv
design/aabb_cr_front.sv
design/aabb_cr_div.sv
design/aabb_collision_resolve_core.sv
design/aabb_cr_checker.sv
tb/aabb_collision_resolve_core_tb.sv
